/* hdl/rotc_pkg.sv */
// Package for the report-on-change trigger: register map, reset values,
// sample and report payload types, configuration struct and field codes.
// No dependencies; every other file of the block imports it.
package rotc_pkg;

   // Register map: register i sits at byte address 4*i.
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_LOW_BATTERY      = 3'd0,
      REG_CRITICAL_BATTERY = 3'd1,
      REG_CHANGE_THRESHOLD = 3'd2,
      REG_HEARTBEAT        = 3'd3,
      REG_COOLDOWN         = 3'd4,
      REG_RADIO_READY      = 3'd5
   } reg_index_type;

   localparam logic [15:0] LOW_BATTERY_RESET      = 16'd3500;
   localparam logic [15:0] CRITICAL_BATTERY_RESET = 16'd3300;
   localparam logic [15:0] CHANGE_THRESHOLD_RESET = 16'd100;
   localparam logic [31:0] HEARTBEAT_RESET        = 32'd3600;
   localparam logic [31:0] COOLDOWN_RESET         = 32'd60;
   localparam logic        RADIO_READY_RESET      = 1'b0;

   // Sensor status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_STALE   = 2'd1;
   localparam logic [1:0] STATUS_FAULT   = 2'd2;
   localparam logic [1:0] STATUS_COMMAND = 2'd3;

   // Sleep mode codes
   localparam logic [1:0] SLEEP_NORMAL   = 2'd0;
   localparam logic [1:0] SLEEP_LOW      = 2'd1;
   localparam logic [1:0] SLEEP_CRITICAL = 2'd2;

   typedef struct packed {
      logic [15:0] low_battery_mv;
      logic [15:0] critical_battery_mv;
      logic [15:0] change_threshold;
      logic [31:0] heartbeat_seconds;
      logic [31:0] cooldown_seconds;
      logic        radio_ready;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        time_seconds;
      logic signed [15:0] pressure;
      logic signed [15:0] temperature;
      logic [15:0]        battery_mv;
      logic [1:0]         sensor_status;
   } sample_type;

   typedef struct packed {
      logic               send;
      logic [15:0]        sequence_res;
      logic signed [15:0] report_pressure;
      logic signed [15:0] report_temperature;
      logic [15:0]        report_battery;
      logic               flag_heartbeat;
      logic               flag_event;
      logic               flag_stale;
      logic               flag_fault;
      logic               flag_low_battery;
      logic [1:0]         sleep_mode;
   } report_type;

endpackage

/* hdl/rotc_if.sv */
// Valid/ready channel interfaces for samples in and reports out.
// Depends on rotc_pkg for the payload structs.
interface rotc_req_if;
   import rotc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rotc_rsp_if;
   import rotc_pkg::*;
   logic       valid;
   logic       ready;
   report_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/report_on_change_trigger.sv */
// Top level of the report-on-change trigger: sample register, decision
// logic, report register and APB register file. Depends on rotc_pkg,
// rotc_if, rotc_csr and rotc_decide.
//
//   Channel   Dir   Handshake               Payload
//   req_chan  in    valid/ready             sample_type (time, pressure, temp, batt, status)
//   rsp_chan  out   valid/ready             report_type (send, sequence, report, flags, sleep)
//   csr_*     in    APB setup + access      32-bit register data, paddr[4:2] selects
//
// One sample per cycle sustained while rsp_chan is ready; each transaction passes
// the sample register, then the report register. The decision is one compare-and-
// update pass over the trigger state between those two registers.
// Reset is synchronous and clears the valid flags, trigger state and CSR fields
// to their reset values. A stall on rsp_chan holds the report register; the
// sample register keeps taking one more transaction before req_chan.ready drops.
module report_on_change_trigger (
   input  logic                                clock,
   input  logic                                reset,
   rotc_req_if.sink                            req_chan,
   rotc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rotc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rotc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rotc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import rotc_pkg::*;

   cfg_type    cfg;

   // sample register
   logic       in_valid_ff, in_valid_in;
   sample_type in_data_ff, in_data_in;

   // report register
   logic       out_valid_ff, out_valid_in;
   report_type out_data_ff, out_data_in;

   report_type report;
   logic       advance;   // sample register moves into report register
   logic       take;      // new transaction accepted on req_chan

   rotc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rotc_decide u_decide (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .sample  (in_data_ff),
      .advance (advance),
      .report  (report)
   );

   // report register is free when empty or being drained this cycle
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_chan.data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = report;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

/* hdl/rotc_csr.sv */
// APB-style register file for the trigger thresholds and radio enable.
// Depends on rotc_pkg for the register map and cfg_type.
module rotc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rotc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [rotc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [rotc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output rotc_pkg::cfg_type                     cfg
);
   import rotc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_LOW_BATTERY:      cfg_in.low_battery_mv      = csr_pwdata[15:0];
            REG_CRITICAL_BATTERY: cfg_in.critical_battery_mv = csr_pwdata[15:0];
            REG_CHANGE_THRESHOLD: cfg_in.change_threshold    = csr_pwdata[15:0];
            REG_HEARTBEAT:        cfg_in.heartbeat_seconds   = csr_pwdata[31:0];
            REG_COOLDOWN:         cfg_in.cooldown_seconds    = csr_pwdata[31:0];
            REG_RADIO_READY:      cfg_in.radio_ready         = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_LOW_BATTERY:      csr_prdata = {16'd0, cfg_ff.low_battery_mv};
         REG_CRITICAL_BATTERY: csr_prdata = {16'd0, cfg_ff.critical_battery_mv};
         REG_CHANGE_THRESHOLD: csr_prdata = {16'd0, cfg_ff.change_threshold};
         REG_HEARTBEAT:        csr_prdata = cfg_ff.heartbeat_seconds;
         REG_COOLDOWN:         csr_prdata = cfg_ff.cooldown_seconds;
         REG_RADIO_READY:      csr_prdata = {31'd0, cfg_ff.radio_ready};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_battery_mv      <= LOW_BATTERY_RESET;
         cfg_ff.critical_battery_mv <= CRITICAL_BATTERY_RESET;
         cfg_ff.change_threshold    <= CHANGE_THRESHOLD_RESET;
         cfg_ff.heartbeat_seconds   <= HEARTBEAT_RESET;
         cfg_ff.cooldown_seconds    <= COOLDOWN_RESET;
         cfg_ff.radio_ready         <= RADIO_READY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/rotc_decide.sv */
// Report decision logic and trigger state (sequence, last report, dying flag).
// Depends on rotc_pkg for cfg_type, sample_type, report_type and codes.
module rotc_decide (
   input  logic                 clock,
   input  logic                 reset,
   input  rotc_pkg::cfg_type    cfg,
   input  rotc_pkg::sample_type sample,
   input  logic                 advance,
   output rotc_pkg::report_type report
);
   import rotc_pkg::*;

   logic [15:0]        next_sequence_ff, next_sequence_in;
   logic               sent_once_ff, sent_once_in;
   logic signed [15:0] last_pressure_ff, last_pressure_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic               dying_ff, dying_in;

   logic               battery_low;
   logic               critical;
   logic               first;
   logic [31:0]        since;
   logic               hb_due;
   logic signed [16:0] delta;
   logic [16:0]        delta_mag;
   logic               hit;
   logic               cool;
   logic               status_ok;
   logic               status_fault;
   logic               normal_send;
   logic               dying_send;
   logic               send;

   assign battery_low  = sample.battery_mv < cfg.low_battery_mv;
   assign critical     = sample.battery_mv < cfg.critical_battery_mv;
   assign first        = !sent_once_ff;
   assign since        = sample.time_seconds - last_time_ff;
   assign hb_due       = since >= cfg.heartbeat_seconds;
   assign delta        = 17'(signed'({sample.pressure[15], sample.pressure}))
                       - 17'(signed'({last_pressure_ff[15], last_pressure_ff}));
   assign delta_mag    = delta[16] ? 17'(-delta) : 17'(delta);
   assign hit          = !first && !battery_low
                      && (delta_mag >= {1'b0, cfg.change_threshold});
   assign cool         = first || (since >= cfg.cooldown_seconds);
   assign status_ok    = sample.sensor_status == STATUS_OK;
   assign status_fault = sample.sensor_status inside {STATUS_FAULT, STATUS_COMMAND};

   assign dying_send  = critical && !dying_ff && cfg.radio_ready;
   assign normal_send = !critical && cool && cfg.radio_ready
                     && (first || (status_ok && (hb_due || hit)) || (status_fault && hb_due));
   assign send        = dying_send || normal_send;

   always_comb begin
      report = '0;
      if (send) begin
         report.send               = 1'b1;
         report.sequence_res       = next_sequence_ff;
         report.report_pressure    = sample.pressure;
         report.report_temperature = sample.temperature;
         report.report_battery     = sample.battery_mv;
         report.flag_heartbeat     = dying_send || hb_due || first;
         report.flag_event         = normal_send && hit;
         report.flag_stale         = sample.sensor_status == STATUS_STALE;
         report.flag_fault         = status_fault;
         report.flag_low_battery   = battery_low;
      end
      if (critical)
         report.sleep_mode = SLEEP_CRITICAL;
      else if (battery_low)
         report.sleep_mode = SLEEP_LOW;
      else
         report.sleep_mode = SLEEP_NORMAL;
   end

   always_comb begin
      next_sequence_in = next_sequence_ff;
      sent_once_in     = sent_once_ff;
      last_pressure_in = last_pressure_ff;
      last_time_in     = last_time_ff;
      dying_in         = dying_ff;
      if (advance) begin
         if (send)
            next_sequence_in = next_sequence_ff + 16'd1;
         if (normal_send) begin
            sent_once_in     = 1'b1;
            last_pressure_in = sample.pressure;
            last_time_in     = sample.time_seconds;
         end
         // re-arm check comes after the announcement in the same sample
         if (!battery_low)
            dying_in = 1'b0;
         else if (dying_send)
            dying_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_sequence_ff <= '0;
         sent_once_ff     <= 1'b0;
         last_pressure_ff <= '0;
         last_time_ff     <= '0;
         dying_ff         <= 1'b0;
      end else begin
         next_sequence_ff <= next_sequence_in;
         sent_once_ff     <= sent_once_in;
         last_pressure_ff <= last_pressure_in;
         last_time_ff     <= last_time_in;
         dying_ff         <= dying_in;
      end
   end

endmodule

/* sim/tb_report_on_change_trigger.sv */
// Self-checking testbench for report_on_change_trigger: directed samples, then random
// sensor traces under several register settings, checked against a behavioral predictor.
// Depends on rotc_pkg, rotc_if and the RTL of the block; nothing else.
module tb_report_on_change_trigger;
   import rotc_pkg::*;

   localparam int HOLD_CYCLES    = 300;    // long receiver hold-off, fills the pipe
   localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transaction
   localparam int SETTLE_CYCLES  = 6;      // two-stage pipe plus margin
   localparam int PHASE_ITEMS    = 130;
   localparam int BURST_ITEMS    = 120;    // back-to-back stretch at the end

   logic clock;
   logic reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   rotc_req_if req_chan();
   rotc_rsp_if rsp_chan();

   report_on_change_trigger u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------
   // Predictor state: shadow registers plus the trigger state
   // ------------------------------------------------------------------
   cfg_type            cfg_shadow;
   logic [15:0]        seq_next;
   logic               reported;        // a normal report went out since reset
   logic signed [15:0] last_pressure;
   logic [31:0]        last_time;
   logic               dying_sent;      // critical announcement already made

   report_type pending_reports[$];      // oldest expected report first
   int  errors;
   int  req_idle_pct;
   int  rsp_idle_pct;
   bit  hold_request;
   int  idle_cycles;
   int  walk_pressure;
   logic [31:0] walk_time;

   // Directed stimulus rows: either a register write or one sample
   typedef struct {
      bit            is_csr;
      reg_index_type idx;
      logic [31:0]   value;
      sample_type    smp;
      bit            typed;   // expected report written out by hand
      report_type    rpt;
   } plan_row_type;

   plan_row_type directed_plan[$];

   // Clock: period 2
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void reset_model();
      cfg_shadow.low_battery_mv      = LOW_BATTERY_RESET;
      cfg_shadow.critical_battery_mv = CRITICAL_BATTERY_RESET;
      cfg_shadow.change_threshold    = CHANGE_THRESHOLD_RESET;
      cfg_shadow.heartbeat_seconds   = HEARTBEAT_RESET;
      cfg_shadow.cooldown_seconds    = COOLDOWN_RESET;
      cfg_shadow.radio_ready         = RADIO_READY_RESET;
      seq_next      = '0;
      reported      = 1'b0;
      last_pressure = '0;
      last_time     = '0;
      dying_sent    = 1'b0;
   endfunction

   // One decision per sample; updates the trigger state as the block does.
   function automatic report_type decide_report(sample_type smp);
      report_type  rpt;
      logic        battery_low, fire, beat, change;
      logic        first_report, beat_due, cool_ok, healthy, broken;
      logic [31:0] elapsed;
      logic [16:0] diff;
      logic [16:0] swing;
      rpt         = '0;
      battery_low = smp.battery_mv < cfg_shadow.low_battery_mv;
      fire        = 1'b0;
      beat        = 1'b0;
      change      = 1'b0;
      if (smp.battery_mv < cfg_shadow.critical_battery_mv) begin
         // critical: a single dying announcement, last report time and pressure untouched
         rpt.sleep_mode = SLEEP_CRITICAL;
         if (!dying_sent && cfg_shadow.radio_ready) begin
            fire       = 1'b1;
            beat       = 1'b1;
            dying_sent = 1'b1;
         end
      end else begin
         first_report = !reported;
         elapsed      = smp.time_seconds - last_time;   // wraps mod 2^32
         beat_due     = elapsed >= cfg_shadow.heartbeat_seconds;
         diff  = {smp.pressure[15], smp.pressure} - {last_pressure[15], last_pressure};
         swing = diff[16] ? -diff : diff;
         change  = !first_report && !battery_low
                && (swing >= {1'b0, cfg_shadow.change_threshold});
         cool_ok = first_report || elapsed >= cfg_shadow.cooldown_seconds;
         healthy = smp.sensor_status == STATUS_OK;
         broken  = smp.sensor_status inside {STATUS_FAULT, STATUS_COMMAND};
         rpt.sleep_mode = battery_low ? SLEEP_LOW : SLEEP_NORMAL;
         if (cool_ok && cfg_shadow.radio_ready &&
             (first_report || (healthy && (beat_due || change)) || (broken && beat_due))) begin
            fire          = 1'b1;
            beat          = beat_due || first_report;
            last_time     = smp.time_seconds;
            last_pressure = smp.pressure;
            reported      = 1'b1;
         end
      end
      // re-arm after the announcement check of this same sample
      if (!battery_low) dying_sent = 1'b0;
      if (fire) begin
         rpt.send               = 1'b1;
         rpt.sequence_res       = seq_next;
         rpt.report_pressure    = smp.pressure;
         rpt.report_temperature = smp.temperature;
         rpt.report_battery     = smp.battery_mv;
         rpt.flag_heartbeat     = beat;
         rpt.flag_event         = change;
         rpt.flag_stale         = smp.sensor_status == STATUS_STALE;
         rpt.flag_fault         = smp.sensor_status inside {STATUS_FAULT, STATUS_COMMAND};
         rpt.flag_low_battery   = battery_low;
         seq_next               = seq_next + 16'd1;
      end
      return rpt;
   endfunction

   function automatic logic [31:0] reg_value(reg_index_type idx);
      case (idx)
         REG_LOW_BATTERY:      return {16'd0, cfg_shadow.low_battery_mv};
         REG_CRITICAL_BATTERY: return {16'd0, cfg_shadow.critical_battery_mv};
         REG_CHANGE_THRESHOLD: return {16'd0, cfg_shadow.change_threshold};
         REG_HEARTBEAT:        return cfg_shadow.heartbeat_seconds;
         REG_COOLDOWN:         return cfg_shadow.cooldown_seconds;
         REG_RADIO_READY:      return {31'd0, cfg_shadow.radio_ready};
         default:              return '0;
      endcase
   endfunction

   function automatic cfg_type make_cfg(logic [15:0] low, logic [15:0] crit, logic [15:0] thr,
                                        logic [31:0] beat, logic [31:0] cool, logic radio);
      cfg_type c;
      c.low_battery_mv      = low;
      c.critical_battery_mv = crit;
      c.change_threshold    = thr;
      c.heartbeat_seconds   = beat;
      c.cooldown_seconds    = cool;
      c.radio_ready         = radio;
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic compare_report(input report_type want, input report_type got);
      check_field("send", 32'(want.send), 32'(got.send));
      check_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
      check_field("report_pressure", 32'(want.report_pressure), 32'(got.report_pressure));
      check_field("report_temperature", 32'(want.report_temperature),
                  32'(got.report_temperature));
      check_field("report_battery", 32'(want.report_battery), 32'(got.report_battery));
      check_field("flag_heartbeat", 32'(want.flag_heartbeat), 32'(got.flag_heartbeat));
      check_field("flag_event", 32'(want.flag_event), 32'(got.flag_event));
      check_field("flag_stale", 32'(want.flag_stale), 32'(got.flag_stale));
      check_field("flag_fault", 32'(want.flag_fault), 32'(got.flag_fault));
      check_field("flag_low_battery", 32'(want.flag_low_battery), 32'(got.flag_low_battery));
      check_field("sleep_mode", 32'(want.sleep_mode), 32'(got.sleep_mode));
   endtask

   // ------------------------------------------------------------------
   // Report receiver: random ready, plus a long hold-off on request.
   // Outputs are read right after the edge, i.e. the values that edge saw.
   // ------------------------------------------------------------------
   initial begin
      report_type want;
      int         hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_reports.size() == 0) begin
               errors++;
               $display("%0t: report transaction with nothing expected, actual %0h",
                        $time, rsp_chan.data);
            end else begin
               want = pending_reports.pop_front();
               compare_report(want, rsp_chan.data);
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: any transaction on any port counts as progress
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_psel && csr_penable && csr_pready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(input reg_index_type idx, input bit wr, input logic [31:0] value,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write a register, mirror it in the shadow copy, then read it back.
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_access(idx, 1'b1, value, rd);
      case (idx)
         REG_LOW_BATTERY:      cfg_shadow.low_battery_mv      = value[15:0];
         REG_CRITICAL_BATTERY: cfg_shadow.critical_battery_mv = value[15:0];
         REG_CHANGE_THRESHOLD: cfg_shadow.change_threshold    = value[15:0];
         REG_HEARTBEAT:        cfg_shadow.heartbeat_seconds   = value;
         REG_COOLDOWN:         cfg_shadow.cooldown_seconds    = value;
         REG_RADIO_READY:      cfg_shadow.radio_ready         = value[0];
         default: ;
      endcase
      csr_access(idx, 1'b0, '0, rd);
      check_field($sformatf("register %s readback", idx.name()), reg_value(idx), rd);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_register(REG_LOW_BATTERY, {16'd0, c.low_battery_mv});
      write_register(REG_CRITICAL_BATTERY, {16'd0, c.critical_battery_mv});
      write_register(REG_CHANGE_THRESHOLD, {16'd0, c.change_threshold});
      write_register(REG_HEARTBEAT, c.heartbeat_seconds);
      write_register(REG_COOLDOWN, c.cooldown_seconds);
      write_register(REG_RADIO_READY, {31'd0, c.radio_ready});
   endtask

   // Offer one sample until accepted, record its expected report, then
   // maybe leave a gap. Valid is only lowered in a gap, never in the same
   // step in which the next sample raises it.
   task automatic send_sample(input sample_type smp, input bit typed, input report_type typed_rpt);
      report_type predicted;
      req_chan.valid <= 1'b1;
      req_chan.data  <= smp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = decide_report(smp);
      pending_reports.push_back(typed ? typed_rpt : predicted);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Sender pause: stop offering until every expected report has arrived.
   task automatic drain_reports();
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random sample: mostly a plausible sensor trace (time moving forward,
   // pressure wandering, battery near the thresholds), sometimes pure noise.
   function automatic sample_type random_sample();
      sample_type s;
      int         off;
      s.temperature = 16'($urandom);
      if ($urandom_range(99) < 12) begin
         s.time_seconds  = $urandom;
         s.pressure      = 16'($urandom);
         s.battery_mv    = 16'($urandom);
         s.sensor_status = 2'($urandom_range(3));
         return s;
      end
      walk_time = walk_time + $urandom_range(0, 90);
      if ($urandom_range(29) == 0) walk_time = walk_time + $urandom;
      walk_pressure = walk_pressure + int'($urandom_range(0, 600)) - 300;
      if ($urandom_range(24) == 0) walk_pressure = $urandom_range(1) ? 32767 : -32768;
      if (walk_pressure > 32767) walk_pressure = 32767;
      if (walk_pressure < -32768) walk_pressure = -32768;
      off = int'($urandom_range(4)) - 2;
      case ($urandom_range(4))
         0:       s.battery_mv = 16'(int'(cfg_shadow.low_battery_mv) + off);
         1:       s.battery_mv = 16'(int'(cfg_shadow.critical_battery_mv) + off);
         2:       s.battery_mv = 16'($urandom_range(65535));
         default: s.battery_mv = 16'd4200;
      endcase
      s.time_seconds  = walk_time;
      s.pressure      = 16'(walk_pressure);
      s.sensor_status = ($urandom_range(99) < 85) ? STATUS_OK : 2'($urandom_range(3));
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Directed plan helpers
   // ------------------------------------------------------------------
   function automatic void plan_sample(logic [31:0] t, int p, int temp, logic [15:0] batt,
                                       logic [1:0] status, bit typed = 1'b0,
                                       report_type rpt = '0);
      plan_row_type row;
      row.is_csr             = 1'b0;
      row.idx                = REG_LOW_BATTERY;
      row.value              = '0;
      row.smp.time_seconds   = t;
      row.smp.pressure       = 16'(p);
      row.smp.temperature    = 16'(temp);
      row.smp.battery_mv     = batt;
      row.smp.sensor_status  = status;
      row.typed              = typed;
      row.rpt                = rpt;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_csr(reg_index_type idx, logic [31:0] value);
      plan_row_type row;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.value  = value;
      row.smp    = '0;
      row.typed  = 1'b0;
      row.rpt    = '0;
      directed_plan.push_back(row);
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      report_type    rpt;
      cfg_type       phase_cfg[7];
      reg_index_type r;
      logic [31:0]   rd;

      errors          = 0;
      req_idle_pct    = 38;
      rsp_idle_pct    = 38;
      hold_request    = 1'b0;
      walk_pressure   = 0;
      walk_time       = 32'h100;
      reset_model();

      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every register must read back its reset value
      r = r.first();
      repeat (r.num()) begin
         csr_access(r, 1'b0, '0, rd);
         check_field($sformatf("register %s after reset", r.name()), reg_value(r), rd);
         r = r.next();
      end

      // ---- directed part ----
      // Radio is down after reset: nothing is sent, only sleep_mode is live.
      rpt = '0;
      rpt.sleep_mode = SLEEP_NORMAL;
      plan_sample(32'd0, 50, 2000, 16'd4000, STATUS_OK, 1'b1, rpt);
      rpt.sleep_mode = SLEEP_LOW;
      plan_sample(32'd5, 50, 2000, 16'd3400, STATUS_OK, 1'b1, rpt);
      rpt.sleep_mode = SLEEP_CRITICAL;
      plan_sample(32'd8, 50, 2000, 16'd3000, STATUS_OK, 1'b1, rpt);
      plan_csr(REG_RADIO_READY, 32'd1);
      // First report goes out even with stale data and the most negative pressure.
      rpt = '0;
      rpt.send               = 1'b1;
      rpt.sequence_res       = 16'd0;
      rpt.report_pressure    = 16'sh8000;
      rpt.report_temperature = 16'sh8000;
      rpt.report_battery     = 16'd4000;
      rpt.flag_heartbeat     = 1'b1;
      rpt.flag_stale         = 1'b1;
      rpt.sleep_mode         = SLEEP_NORMAL;
      plan_sample(32'd100, -32768, -32768, 16'd4000, STATUS_STALE, 1'b1, rpt);
      plan_sample(32'd110, 32767, 32767, 16'd4000, STATUS_OK);       // inside cooldown
      plan_sample(32'd160, 32767, 1, 16'd4000, STATUS_OK);           // full-scale change
      plan_sample(32'd230, 32668, 2, 16'd4000, STATUS_OK);           // one below threshold
      plan_sample(32'd300, 32667, 3, 16'd4000, STATUS_OK);           // exactly threshold
      plan_sample(32'd400, 0, 4, 16'd4000, STATUS_STALE);            // stale never reports again
      plan_sample(32'd500, 0, 5, 16'd4000, STATUS_FAULT);            // fault without heartbeat
      plan_sample(32'd3900, 0, 6, 16'd4000, STATUS_COMMAND);         // heartbeat under fault
      plan_sample(32'd4000, 1000, 7, 16'd3400, STATUS_OK);           // low battery, no change report
      plan_sample(32'd7500, 1000, 8, 16'd3400, STATUS_OK);           // low-battery heartbeat
      plan_sample(32'd7600, 1000, 9, 16'd3299, STATUS_OK);           // dying announcement
      plan_sample(32'd7700, 1000, 10, 16'd0, STATUS_OK);             // already announced
      plan_sample(32'd7800, 1000, 11, 16'd3499, STATUS_OK);          // low, not yet re-armed
      plan_sample(32'd7900, 1000, 12, 16'd3299, STATUS_OK);          // still silent
      plan_sample(32'd8000, 1000, 13, 16'd3500, STATUS_OK);          // back at low level: re-arm
      plan_sample(32'd8100, 1000, 14, 16'd3200, STATUS_OK);          // second announcement
      plan_sample(32'hFFFF_FFFF, 5000, 15, 16'hFFFF, STATUS_OK);     // heartbeat near time wrap
      plan_sample(32'h0000_0020, -5000, 16, 16'd4000, STATUS_OK);    // cooldown across the wrap
      plan_sample(32'h0000_003C, -5000, 17, 16'd4000, STATUS_OK);    // change after the wrap

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_csr) begin
            drain_reports();
            write_register(directed_plan[i].idx, directed_plan[i].value);
         end else begin
            send_sample(directed_plan[i].smp, directed_plan[i].typed, directed_plan[i].rpt);
         end
      end

      // ---- random part, one register setting per phase ----
      phase_cfg[0] = make_cfg(16'd3500, 16'd3300, 16'd100, 32'd600, 32'd30, 1'b1);
      phase_cfg[1] = make_cfg(16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
      phase_cfg[2] = make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
      phase_cfg[3] = make_cfg(16'd3500, 16'd3300, 16'd50, 32'd200, 32'd0, 1'b1);
      phase_cfg[4] = make_cfg(16'd3300, 16'd3500, 16'd150, 32'd100, 32'd20, 1'b1); // crit above low
      phase_cfg[5] = make_cfg(16'd3500, 16'd3300, 16'd100, 32'd3600, 32'd60, 1'b0); // radio down
      phase_cfg[6] = make_cfg(16'($urandom), 16'($urandom), 16'($urandom),
                              $urandom_range(0, 400), $urandom_range(0, 100), 1'b1);

      foreach (phase_cfg[ph]) begin
         drain_reports();
         apply_settings(phase_cfg[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // receiver stalls for a long time while samples keep coming
            if (ph == 3 && n == 10) hold_request = 1'b1;
            // sender pauses mid-phase until the pipe is empty
            if (ph == 0 && n == PHASE_ITEMS / 2) drain_reports();
            send_sample(random_sample(), 1'b0, '0);
         end
      end

      // ---- back-to-back burst with no idling on either side ----
      drain_reports();
      apply_settings(make_cfg(16'd0, 16'd0, 16'($urandom), 32'd0, 32'd0, 1'b1));
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int n = 0; n < BURST_ITEMS; n++) begin
         rpt = '0;
         send_sample(random_sample(), 1'b0, rpt);
      end
      req_idle_pct = 38;
      rsp_idle_pct = 38;

      // ---- end of run: everything expected must have arrived ----
      drain_reports();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
hdl/rotc_pkg.sv
hdl/rotc_if.sv
hdl/rotc_csr.sv
hdl/rotc_decide.sv
hdl/report_on_change_trigger.sv
sim/tb_report_on_change_trigger.sv
